>>> src/stbs_pkg.sv
package stbs_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 256;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef logic [2:0] step_t;

    localparam step_t ST_IDLE  = 3'd0;
    localparam step_t ST_PROBE = 3'd1;
    localparam step_t ST_CMP   = 3'd2;
    localparam step_t ST_HIT   = 3'd3;
    localparam step_t ST_MISS  = 3'd4;

    typedef enum logic [1:0] {
        C_SEARCH = 2'd0,
        C_EMPTY  = 2'd1,
        C_EQ     = 2'd2,
        C_BUSY   = 2'd3
    } cond_sel_t;

    // datapath controls of one microcode word
    typedef struct packed {
        logic in_ready;
        logic rd;
        logic cmp;
        logic emit;
        logic hit;
    } ctrl_t;

    // condition flags back from the datapath
    typedef struct packed {
        logic search;
        logic empty;
        logic eq;
        logic busy;
    } cond_t;

    typedef struct packed {
        ctrl_t     ops;
        cond_sel_t cond;
        step_t     jmp;
        step_t     nxt;
    } uword_t;

    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '{ops: '0, cond: C_BUSY, jmp: ST_IDLE, nxt: ST_IDLE};
        unique case (step)
            ST_IDLE: begin
                w.ops.in_ready = 1'b1;
                w.cond = C_SEARCH;
                w.jmp  = ST_PROBE;
                w.nxt  = ST_IDLE;
            end
            ST_PROBE: begin
                w.ops.rd = 1'b1;
                w.cond = C_EMPTY;
                w.jmp  = ST_MISS;
                w.nxt  = ST_CMP;
            end
            ST_CMP: begin
                w.ops.cmp = 1'b1;
                w.cond = C_EQ;
                w.jmp  = ST_HIT;
                w.nxt  = ST_PROBE;
            end
            ST_HIT: begin
                w.ops.emit = 1'b1;
                w.ops.hit  = 1'b1;
                w.cond = C_BUSY;
                w.jmp  = ST_HIT;
                w.nxt  = ST_IDLE;
            end
            ST_MISS: begin
                w.ops.emit = 1'b1;
                w.cond = C_BUSY;
                w.jmp  = ST_MISS;
                w.nxt  = ST_IDLE;
            end
            default: begin
                w.nxt = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> src/sorted_table_binary_search.sv
// channel | direction | tdata (low bit up)                            | tuser
// s_      | in        | entry_index[7:0], entry_value[39:8],          | opcode
//         |           | search_key[71:40]                             |
// m_      | out       | position[7:0]                                 | found
// cfg_    | in        | cfg_wr_data[8:0] = entry_count                | -
// A write item is taken in IDLE, which stays ready for the next item. A search
// item is taken in IDLE, then loops through the microcode steps PROBE (address
// then registered table read) and CMP (compare) until a hit or an empty range;
// HIT or MISS then posts the result; a miss is found by the range check in PROBE.
// aresetn is synchronous; it clears the step counter, entry_count and the result
// valid and holds s_tready low; the table holds garbage until written. A result
// waits in the output register while the next item is taken; the sequencer
// stalls only if it is still full.
module sorted_table_binary_search #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [stbs_pkg::CFG_W-1:0]     cfg_wr_data,   // entry_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [stbs_pkg::S_DATA_W-1:0]  s_tdata,       // entry_index, entry_value, search_key
    input  logic                           s_tuser,       // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stbs_pkg::M_DATA_W-1:0]  m_tdata,       // position
    output logic                           m_tuser        // found
);
    import stbs_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = AW + 1;

    ctrl_t ctrl;
    cond_t cond;

    logic [CFG_W-1:0]         count_reg;
    logic [VALUE_W-1:0]       mem [TABLE_DEPTH];
    logic [VALUE_W-1:0]       rdata_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic [CW-1:0]            lo_reg, lo_next;
    logic [CW-1:0]            hi_reg, hi_next;
    logic [AW-1:0]            mid_reg;
    logic [AW-1:0]            mid;
    logic [CW:0]              mid_sum;
    logic [CW-1:0]            n_sat;
    logic                     acc;
    logic                     wr_ok;
    logic [INDEX_W-1:0]       s_index;
    logic [VALUE_W-1:0]       s_value;
    logic [VALUE_W-1:0]       s_key;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_found_reg;
    logic [POS_W-1:0]         m_pos_reg;
    logic                     out_busy;
    logic                     eq;
    logic                     gt;

    stbs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ctrl    (ctrl)
    );

    assign s_index = s_tdata[INDEX_W-1:0];
    assign s_value = s_tdata[INDEX_W +: VALUE_W];
    assign s_key   = s_tdata[INDEX_W+VALUE_W +: VALUE_W];

    assign s_tready = ctrl.in_ready && aresetn;
    assign acc      = s_tvalid && s_tready;
    assign wr_ok    = acc && (s_tuser == OP_WRITE) && (32'(s_index) < 32'(TABLE_DEPTH));

    assign n_sat = (32'(count_reg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_reg);

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid     = mid_sum[AW:1];

    assign eq       = ($signed(rdata_reg) == key_reg);
    assign gt       = ($signed(rdata_reg) > key_reg);
    assign out_busy = m_valid_reg && !m_tready;

    assign cond.search = acc && (s_tuser == OP_SEARCH);
    assign cond.empty  = (lo_reg >= hi_reg);
    assign cond.eq     = eq;
    assign cond.busy   = out_busy;

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cond.search) begin
            lo_next = '0;
            hi_next = n_sat;
        end else if (ctrl.cmp && !eq) begin
            if (gt) begin
                hi_next = {1'b0, mid_reg};
            end else begin
                lo_next = {1'b0, mid_reg} + {{AW{1'b0}}, 1'b1};
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (ctrl.emit && !out_busy) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[AW'(s_index)] <= s_value;
        end
        if (ctrl.rd) begin
            rdata_reg <= mem[mid];
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cond.search) begin
            key_reg <= $signed(s_key);
        end
        if (ctrl.rd) begin
            mid_reg <= mid;
        end
        if (ctrl.emit && !out_busy) begin
            m_found_reg <= ctrl.hit;
            m_pos_reg   <= ctrl.hit ? POS_W'(mid_reg) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pos_reg;
    assign m_tuser  = m_found_reg;

endmodule

>>> src/stbs_seq.sv
module stbs_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  stbs_pkg::cond_t cond,
    output stbs_pkg::ctrl_t ctrl
);
    import stbs_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   take;

    assign word = ucode(step_reg);
    assign ctrl = word.ops;

    always_comb begin
        unique case (word.cond)
            C_SEARCH: take = cond.search;
            C_EMPTY:  take = cond.empty;
            C_EQ:     take = cond.eq;
            C_BUSY:   take = cond.busy;
        endcase
        step_next = take ? word.jmp : word.nxt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule
